// ===== rtl/core/hbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hbp_pkg: shared types and constants of the hybrid branch predictor
// Table sizes, counter codes and the saturating update functions.
// ----------------------------------------------------------------------------
package hbp_pkg;

  localparam int CHOOSER_INDEX_BITS = 8;
  localparam int GSHARE_INDEX_BITS  = 10;
  localparam int HISTORY_BITS       = 6;
  localparam int BIMODAL_INDEX_BITS = 10;

  localparam int CHOOSER_DEPTH = 1 << CHOOSER_INDEX_BITS;
  localparam int GSHARE_DEPTH  = 1 << GSHARE_INDEX_BITS;
  localparam int BIMODAL_DEPTH = 1 << BIMODAL_INDEX_BITS;

  // the clearing sweep walks the deepest table; smaller ones wrap
  localparam int CLR_BITS_GB = (GSHARE_INDEX_BITS > BIMODAL_INDEX_BITS) ?
                               GSHARE_INDEX_BITS : BIMODAL_INDEX_BITS;
  localparam int CLR_BITS    = (CLR_BITS_GB > CHOOSER_INDEX_BITS) ?
                               CLR_BITS_GB : CHOOSER_INDEX_BITS;

  localparam int CHOOSER_W = 2;
  localparam int CTR_W     = 3;

  typedef logic [CHOOSER_W-1:0] chooser_t;
  typedef logic [CTR_W-1:0]     ctr_t;

  localparam chooser_t CHOOSER_INIT      = 2'd1;
  localparam chooser_t CHOOSER_MAX       = 2'd3;
  localparam chooser_t CHOOSER_MIN       = 2'd0;
  localparam chooser_t CHOOSER_PICK_GSH  = 2'd2;
  localparam ctr_t     CTR_INIT          = 3'd4;
  localparam ctr_t     CTR_MAX           = 3'd7;
  localparam ctr_t     CTR_MIN           = 3'd0;

  function automatic ctr_t train_ctr(input ctr_t c, input logic up);
    ctr_t res;
    res = c;
    if (up) begin
      if (c != CTR_MAX) res = c + ctr_t'(1);
    end else begin
      if (c != CTR_MIN) res = c - ctr_t'(1);
    end
    return res;
  endfunction

  // move toward the component that alone was right
  function automatic chooser_t train_chooser(input chooser_t c, input logic g_ok,
                                             input logic b_ok);
    chooser_t res;
    res = c;
    if (g_ok && !b_ok) begin
      if (c != CHOOSER_MAX) res = c + chooser_t'(1);
    end else if (b_ok && !g_ok) begin
      if (c != CHOOSER_MIN) res = c - chooser_t'(1);
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/hybrid_branch_predictor.sv =====
// ----------------------------------------------------------------------------
// hybrid_branch_predictor: gshare / bimodal predictor with per-PC chooser
// An accepted beat passes the read stage, then the output register, before it
// is presented at the output. One beat per cycle is accepted unless the output
// stalls, bounded by the table RAMs' single read and write port each. After
// reset the tables are cleared by a sweep over 1024 addresses (one entry per
// cycle) during which in_stall stays high.
// ----------------------------------------------------------------------------
module hybrid_branch_predictor
  import hbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_branch_pc,
  input  logic        in_branch_taken,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_predicted_taken,
  output logic        out_prediction_correct,
  output logic        out_used_gshare,
  output logic [31:0] out_correct_total
);

  logic                          acc;
  logic                          p_adv;

  logic                          clr_busy_r;
  logic [CLR_BITS-1:0]           clr_r;

  logic [HISTORY_BITS-1:0]       hist_r;
  logic [HISTORY_BITS-1:0]       hist_nxt;

  logic [CHOOSER_INDEX_BITS-1:0] in_ci;
  logic [GSHARE_INDEX_BITS-1:0]  in_gi;
  logic [BIMODAL_INDEX_BITS-1:0] in_bi;

  // read stage
  logic                          p_valid_r;
  logic                          p_taken_r;
  logic [CHOOSER_INDEX_BITS-1:0] p_ci_r;
  logic [GSHARE_INDEX_BITS-1:0]  p_gi_r;
  logic [BIMODAL_INDEX_BITS-1:0] p_bi_r;
  logic                          p_cfwd_r, p_gfwd_r, p_bfwd_r;
  chooser_t                      p_cdat_r;
  ctr_t                          p_gdat_r, p_bdat_r;

  chooser_t                      ch_rdata, ch_cur, ch_new;
  ctr_t                          g_rdata, g_cur, g_new;
  ctr_t                          b_rdata, b_cur, b_new;
  logic                          use_g, g_pred, b_pred, pred, ok;

  logic                          ch_we, g_we, b_we;
  logic [CHOOSER_INDEX_BITS-1:0] ch_waddr;
  logic [GSHARE_INDEX_BITS-1:0]  g_waddr;
  logic [BIMODAL_INDEX_BITS-1:0] b_waddr;
  chooser_t                      ch_wdata;
  ctr_t                          g_wdata, b_wdata;

  logic [31:0]                   cnt_r;
  logic [31:0]                   cnt_nxt;

  // output register
  logic                          o_valid_r;
  logic                          o_pred_r, o_ok_r, o_used_g_r;
  logic [31:0]                   o_total_r;

  assign p_adv    = p_valid_r & (~o_valid_r | ~out_stall);
  assign in_stall = clr_busy_r | (p_valid_r & ~p_adv);
  assign acc      = in_valid & ~in_stall;

  assign in_ci    = in_branch_pc[CHOOSER_INDEX_BITS+1:2];
  assign in_gi    = in_branch_pc[GSHARE_INDEX_BITS+1:2] ^ GSHARE_INDEX_BITS'(hist_r);
  assign in_bi    = in_branch_pc[BIMODAL_INDEX_BITS+1:2];
  assign hist_nxt = (hist_r >> 1) |
                    (HISTORY_BITS'(in_branch_taken) << (HISTORY_BITS - 1));

  // take the value written at the accept edge over the stale RAM read
  assign ch_cur = p_cfwd_r ? p_cdat_r : ch_rdata;
  assign g_cur  = p_gfwd_r ? p_gdat_r : g_rdata;
  assign b_cur  = p_bfwd_r ? p_bdat_r : b_rdata;

  assign use_g  = ch_cur >= CHOOSER_PICK_GSH;
  assign g_pred = g_cur >= CTR_INIT;
  assign b_pred = b_cur >= CTR_INIT;
  assign pred   = use_g ? g_pred : b_pred;
  assign ok     = pred == p_taken_r;

  assign g_new  = train_ctr(g_cur, p_taken_r);
  assign b_new  = train_ctr(b_cur, p_taken_r);
  assign ch_new = train_chooser(ch_cur, g_pred == p_taken_r, b_pred == p_taken_r);

  assign cnt_nxt = cnt_r + 32'(ok);

  assign ch_we    = clr_busy_r | p_adv;
  assign g_we     = clr_busy_r | (p_adv & use_g);
  assign b_we     = clr_busy_r | (p_adv & ~use_g);
  assign ch_waddr = clr_busy_r ? clr_r[CHOOSER_INDEX_BITS-1:0] : p_ci_r;
  assign g_waddr  = clr_busy_r ? clr_r[GSHARE_INDEX_BITS-1:0]  : p_gi_r;
  assign b_waddr  = clr_busy_r ? clr_r[BIMODAL_INDEX_BITS-1:0] : p_bi_r;
  assign ch_wdata = clr_busy_r ? CHOOSER_INIT : ch_new;
  assign g_wdata  = clr_busy_r ? CTR_INIT : g_new;
  assign b_wdata  = clr_busy_r ? CTR_INIT : b_new;

  hbp_ram #(.WIDTH(CHOOSER_W), .DEPTH(CHOOSER_DEPTH)) u_chooser_ram (
    .clk   (clk),
    .we    (ch_we),
    .waddr (ch_waddr),
    .wdata (ch_wdata),
    .re    (acc),
    .raddr (in_ci),
    .rdata (ch_rdata)
  );

  hbp_ram #(.WIDTH(CTR_W), .DEPTH(GSHARE_DEPTH)) u_gshare_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .re    (acc),
    .raddr (in_gi),
    .rdata (g_rdata)
  );

  hbp_ram #(.WIDTH(CTR_W), .DEPTH(BIMODAL_DEPTH)) u_bimodal_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .re    (acc),
    .raddr (in_bi),
    .rdata (b_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_r      <= '0;
      hist_r     <= '0;
      cnt_r      <= '0;
      p_valid_r  <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_r <= clr_r + CLR_BITS'(1);
        if (&clr_r) clr_busy_r <= 1'b0;
      end
      if (acc) hist_r <= hist_nxt;
      if (p_adv) cnt_r <= cnt_nxt;
      if (acc) begin
        p_valid_r <= 1'b1;
      end else if (p_adv) begin
        p_valid_r <= 1'b0;
      end
      if (p_adv) begin
        o_valid_r <= 1'b1;
      end else if (!out_stall) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (acc) begin
      p_taken_r <= in_branch_taken;
      p_ci_r    <= in_ci;
      p_gi_r    <= in_gi;
      p_bi_r    <= in_bi;
      p_cfwd_r  <= p_adv & (p_ci_r == in_ci);
      p_gfwd_r  <= p_adv & use_g & (p_gi_r == in_gi);
      p_bfwd_r  <= p_adv & ~use_g & (p_bi_r == in_bi);
      p_cdat_r  <= ch_new;
      p_gdat_r  <= g_new;
      p_bdat_r  <= b_new;
    end
    if (p_adv) begin
      o_pred_r   <= pred;
      o_ok_r     <= ok;
      o_used_g_r <= use_g;
      o_total_r  <= cnt_nxt;
    end
  end

  assign out_valid              = o_valid_r;
  assign out_predicted_taken    = o_pred_r;
  assign out_prediction_correct = o_ok_r;
  assign out_used_gshare        = o_used_g_r;
  assign out_correct_total      = o_total_r;

endmodule

// ===== rtl/core/hbp_ram.sv =====
// ----------------------------------------------------------------------------
// hbp_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/hbp_checker.sv =====
// ----------------------------------------------------------------------------
// hbp_checker: port-level checks for the hybrid branch predictor
// Watches both channels and the running total of correct predictions.
// ----------------------------------------------------------------------------
module hbp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_predicted_taken,
  input logic        out_prediction_correct,
  input logic        out_used_gshare,
  input logic [31:0] out_correct_total
);

  logic        in_acc, out_acc;
  logic [2:0]  inflight_r;
  logic [31:0] last_total_r;

  assign in_acc  = in_valid & ~in_stall;
  assign out_acc = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r   <= '0;
      last_total_r <= '0;
    end else begin
      inflight_r <= inflight_r + 3'(in_acc) - 3'(out_acc);
      if (out_acc) last_total_r <= out_correct_total;
    end
  end

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_correct_total) &&
      $stable(out_predicted_taken) && $stable(out_prediction_correct) &&
      $stable(out_used_gshare))
    else $error("stalled result beat changed");

  // the clearing sweep blocks input right after reset
  a_clear_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken during table clear");

  // no result beat without an input beat in flight
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 3'd0)
    else $error("result beat without accepted input");

  // the total advances by exactly the correct flag of each beat
  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> out_correct_total == last_total_r + 32'(out_prediction_correct))
    else $error("correct total out of step");

  // result flags are known on every valid beat
  a_pred_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_predicted_taken, out_prediction_correct,
                               out_used_gshare}))
    else $error("unknown result flags");

endmodule

bind hybrid_branch_predictor hbp_checker u_hbp_checker (.*);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for hybrid_branch_predictor
// Streams resolved branches through the valid/stall ports. A scoreboard keeps
// its own chooser, gshare and bimodal tables and its own history, predicts
// every result beat and compares each returned beat field by field.
// ----------------------------------------------------------------------------
module testbench
  import hbp_pkg::*;
();

  localparam int   RANDOM_BRANCHES = 1450;
  localparam int   CYCLE_LIMIT     = 400000;
  localparam int   HOT_SLOTS       = 8;
  localparam ctr_t TAKEN_LEVEL     = 3'd4;

  typedef struct packed {
    logic        predicted;
    logic        correct;
    logic        gshare;
    logic [31:0] total;
  } verdict_t;

  typedef struct packed {
    logic [31:0] pc;
    logic        taken;
  } branch_t;

  class branch_scoreboard;
    chooser_t                chooser_tbl[CHOOSER_DEPTH];
    ctr_t                    gshare_tbl[GSHARE_DEPTH];
    ctr_t                    bimodal_tbl[BIMODAL_DEPTH];
    logic [HISTORY_BITS-1:0] history;
    logic [31:0]             hits;
    verdict_t                expected_verdicts[$];
    int unsigned             failures;

    function new();
      foreach (chooser_tbl[i]) chooser_tbl[i] = CHOOSER_INIT;
      foreach (gshare_tbl[i]) gshare_tbl[i] = CTR_INIT;
      foreach (bimodal_tbl[i]) bimodal_tbl[i] = CTR_INIT;
      history = '0;
      hits = '0;
      failures = 0;
    endfunction

    function int unsigned pending();
      return expected_verdicts.size();
    endfunction

    // predict the branch, then train the tables the same way the block does
    function void note_branch(logic [31:0] pc, logic taken);
      logic [31:0] word;
      int unsigned ci, gi, bi;
      logic        use_g, g_pred, b_pred, g_ok, b_ok, pred;
      verdict_t    v;
      word = {2'b00, pc[31:2]};
      ci = word & (CHOOSER_DEPTH - 1);
      gi = (word ^ {{(32-HISTORY_BITS){1'b0}}, history}) & (GSHARE_DEPTH - 1);
      bi = word & (BIMODAL_DEPTH - 1);
      use_g  = chooser_tbl[ci] >= CHOOSER_PICK_GSH;
      g_pred = gshare_tbl[gi] >= TAKEN_LEVEL;
      b_pred = bimodal_tbl[bi] >= TAKEN_LEVEL;
      g_ok   = g_pred == taken;
      b_ok   = b_pred == taken;
      pred   = use_g ? g_pred : b_pred;
      if (pred == taken) hits = hits + 32'd1;
      if (use_g) begin
        if (taken && gshare_tbl[gi] != CTR_MAX) gshare_tbl[gi] = gshare_tbl[gi] + 3'd1;
        else if (!taken && gshare_tbl[gi] != CTR_MIN) gshare_tbl[gi] = gshare_tbl[gi] - 3'd1;
      end else begin
        if (taken && bimodal_tbl[bi] != CTR_MAX) bimodal_tbl[bi] = bimodal_tbl[bi] + 3'd1;
        else if (!taken && bimodal_tbl[bi] != CTR_MIN) bimodal_tbl[bi] = bimodal_tbl[bi] - 3'd1;
      end
      history = {taken, history[HISTORY_BITS-1:1]};
      // leave the chooser alone when both components agree on being right or wrong
      if (g_ok && !b_ok && chooser_tbl[ci] != CHOOSER_MAX)
        chooser_tbl[ci] = chooser_tbl[ci] + 2'd1;
      else if (b_ok && !g_ok && chooser_tbl[ci] != CHOOSER_MIN)
        chooser_tbl[ci] = chooser_tbl[ci] - 2'd1;
      v.predicted = pred;
      v.correct   = pred == taken;
      v.gshare    = use_g;
      v.total     = hits;
      expected_verdicts.insert(expected_verdicts.size(), v);
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        $display("%0t: result beat with nothing expected: pred %0d ok %0d gsh %0d total %0d",
                 $time, got.predicted, got.correct, got.gshare, got.total);
        failures++;
        return;
      end
      want = expected_verdicts.pop_front();
      if (got.predicted !== want.predicted) begin
        $display("%0t: predicted_taken expected %0d actual %0d", $time, want.predicted,
                 got.predicted);
        failures++;
      end
      if (got.correct !== want.correct) begin
        $display("%0t: prediction_correct expected %0d actual %0d", $time, want.correct,
                 got.correct);
        failures++;
      end
      if (got.gshare !== want.gshare) begin
        $display("%0t: used_gshare expected %0d actual %0d", $time, want.gshare, got.gshare);
        failures++;
      end
      if (got.total !== want.total) begin
        $display("%0t: correct_total expected %0d actual %0d", $time, want.total, got.total);
        failures++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_branch_pc;
  logic        in_branch_taken;
  logic        out_valid;
  logic        out_stall;
  logic        out_predicted_taken;
  logic        out_prediction_correct;
  logic        out_used_gshare;
  logic [31:0] out_correct_total;

  branch_scoreboard sb;
  branch_t          branch_q[$];
  int unsigned      cycle_count = 0;

  hybrid_branch_predictor uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_branch_pc           (in_branch_pc),
    .in_branch_taken        (in_branch_taken),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_predicted_taken    (out_predicted_taken),
    .out_prediction_correct (out_prediction_correct),
    .out_used_gshare        (out_used_gshare),
    .out_correct_total      (out_correct_total)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial sb = new();

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_branch(in_branch_pc, in_branch_taken);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_verdict({out_predicted_taken, out_prediction_correct, out_used_gshare,
                        out_correct_total});
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void push_branch(logic [31:0] pc, logic taken);
    branch_t b;
    b.pc = pc;
    b.taken = taken;
    branch_q.insert(branch_q.size(), b);
  endfunction

  // receiver: stall pattern of its own, with a long hold-off now and then
  initial begin
    int unsigned seg, mode, len;
    seg = 0;
    forever begin
      seg++;
      if (seg % 60 == 40) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        len = $urandom_range(5, 60);
        for (int k = 0; k < len; k++) begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 1);
            default: out_stall <= (k % 4 == 3);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    logic [31:0] hot_pc[HOT_SLOTS];
    logic [31:0] pc_a, pc_b;
    logic [3:0]  pattern;
    int unsigned kind, trips, reps, len, idx, burst, gap;
    bit          paused;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_branch_pc <= '0;
    in_branch_taken <= 1'b0;

    // field extremes and odd address bits
    push_branch(32'h0000_0000, 1'b1);
    push_branch(32'hFFFF_FFFF, 1'b0);
    push_branch(32'hFFFF_FFFC, 1'b1);
    push_branch(32'h0000_0003, 1'b0);
    push_branch(32'h8000_0000, 1'b1);
    push_branch(32'h5555_5555, 1'b0);
    push_branch(32'hAAAA_AAAA, 1'b1);
    // drive one bimodal counter to the floor, then run the same branch taken
    repeat (6) push_branch(32'h0000_0100, 1'b0);
    repeat (9) push_branch(32'h0000_0100, 1'b1);
    // alternate so gshare is right where bimodal is not
    for (int k = 0; k < 3; k++) push_branch(32'h0000_0204, k[0]);

    foreach (hot_pc[i]) hot_pc[i] = $urandom;
    while (branch_q.size() < 25 + RANDOM_BRANCHES) begin
      kind = $urandom_range(0, 9);
      pc_a = hot_pc[$urandom_range(0, HOT_SLOTS - 1)];
      case (kind)
        0, 1, 2, 3: begin
          // loop branch: taken for the trip count, then falls through
          trips = $urandom_range(1, 8);
          reps = $urandom_range(1, 4);
          repeat (reps) begin
            repeat (trips) push_branch(pc_a, 1'b1);
            push_branch(pc_a, 1'b0);
          end
        end
        4, 5: begin
          pattern = 4'($urandom_range(0, 15));
          len = $urandom_range(4, 16);
          for (int k = 0; k < len; k++) push_branch(pc_a, pattern[2'(k)]);
        end
        6: begin
          // correlated pair: the second follows the first
          pc_b = hot_pc[$urandom_range(0, HOT_SLOTS - 1)];
          reps = $urandom_range(3, 6);
          repeat (reps) begin
            trips = $urandom_range(0, 1);
            push_branch(pc_a, trips[0]);
            push_branch(pc_b, trips[0]);
          end
        end
        7: begin
          // alias onto a hot entry through the upper address bits
          reps = $urandom_range(1, 3);
          repeat (reps) push_branch({20'($urandom), pc_a[11:0]},
                                    1'($urandom_range(0, 1)));
        end
        8: hot_pc[$urandom_range(0, HOT_SLOTS - 1)] = $urandom;
        default: begin
          reps = $urandom_range(1, 4);
          repeat (reps) push_branch($urandom, 1'($urandom_range(0, 1)));
        end
      endcase
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    idx = 0;
    paused = 1'b0;
    while (idx < branch_q.size()) begin
      if (!paused && idx >= branch_q.size() / 2) begin
        // drain everything before going on
        paused = 1'b1;
        in_valid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
        @(posedge clk);
      end
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && idx < branch_q.size(); k++) begin
        in_valid <= 1'b1;
        in_branch_pc <= branch_q[idx].pc;
        in_branch_taken <= branch_q[idx].taken;
        do @(posedge clk); while (in_stall);
        idx++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    do @(negedge clk); while (sb.pending() != 0);
    repeat (8) @(posedge clk);
    if (sb.failures == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
